// ===== hdl/rmst_pkg.sv =====
// Package: types and constants for the range maximum segment tree.
`timescale 1ns / 1ps
package rmst_pkg;

  localparam int MAX_KEYS   = 1024;
  localparam int NODE_COUNT = 2048;
  localparam int SLOT_W     = $clog2(MAX_KEYS);
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int STACK_W    = 4;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INDEX_NONE = -32'sd1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [SLOT_W-1:0]  slot_index;
    logic signed [31:0] key_value;
    logic signed [31:0] entry_index;
    logic signed [31:0] score;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] best_index;
    logic signed [31:0] best_score;
  } result_t;

  typedef struct packed {
    logic signed [31:0] idx;
    logic signed [31:0] score;
  } node_t;

  typedef struct packed {
    logic [NODE_W-1:0] n;
    logic [SLOT_W-1:0] b;
    logic [SLOT_W-1:0] e;
  } frame_t;

  localparam node_t NODE_EMPTY = '{idx: INDEX_NONE, score: SCORE_MIN};

endpackage

// ===== hdl/range_max_segment_tree.sv =====
// Top level: segment tree range maximum query with point updates.
// Load: writes the key and clears the nodes on its slot's root-to-leaf path. Update:
// steers by key down to a leaf, writes it on a key match, then sets each ancestor to
// its larger child. Query: folds each fully covered node, visiting up to 4 per level.
// One item at a time: busy holds off start until the item ends; done strobes each
// result for one cycle and cannot be held off. Reset clears all 2048 nodes.
`timescale 1ns / 1ps
module range_max_segment_tree import rmst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cmd_t             cmd,
  output logic             busy,
  output logic             done,
  output result_t          result,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_U_RD, S_U_CMP, S_P_RD, S_P_WR, S_Q_RD, S_Q_EVAL, S_Q_FOLD
  } state_t;

  state_t state;
  logic [CNT_W-1:0] key_count;
  logic [NODE_W-1:0] clr;
  logic [NODE_W-1:0] n;
  logic [SLOT_W-1:0] b, e;
  logic [SLOT_W-1:0] load_slot;
  logic signed [31:0] key, eidx, esc, lo, hi;
  node_t acc;
  frame_t stack [2**STACK_W];
  logic [STACK_W-1:0] sp;

  logic signed [31:0] key_mem [MAX_KEYS];
  node_t node_mem [NODE_COUNT];
  logic signed [31:0] key_qa, key_qb;
  node_t node_qa, node_qb;

  logic [SLOT_W-1:0] key_ra, key_rb;
  logic [NODE_W-1:0] node_ra, node_rb, node_wa;
  logic node_we;
  node_t node_wd;

  logic accept;
  logic [SLOT_W-1:0] last;
  logic [SLOT_W:0] span_sum;
  logic [SLOT_W-1:0] mid;
  logic leaf, miss, full;
  node_t fold_x, fold_out;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  always_comb begin
    priority if (key_count == '0) begin
      last = '0;
    end else if (key_count > CNT_W'(MAX_KEYS)) begin
      last = SLOT_W'(MAX_KEYS - 1);
    end else begin
      last = SLOT_W'(key_count - CNT_W'(1));
    end
  end

  assign span_sum = {1'b0, b} + {1'b0, e};
  assign mid = span_sum[SLOT_W:1];
  assign leaf = (b == e);
  assign miss = (lo > key_qb) || (hi < key_qa);
  assign full = (key_qa >= lo) && (key_qb <= hi);

  assign fold_x = (state == S_Q_FOLD) ? node_qa : NODE_EMPTY;
  assign fold_out = ((acc.score == SCORE_MIN) || (fold_x.score > acc.score)) ? fold_x : acc;

  always_comb begin
    node_we = 1'b0;
    node_wa = n;
    node_wd = NODE_EMPTY;
    node_ra = {n[NODE_W-2:0], 1'b0};
    node_rb = {n[NODE_W-2:0], 1'b1};
    key_ra  = b;
    key_rb  = e;
    unique case (state)
      S_CLEAR: begin
        node_we = 1'b1;
        node_wa = clr;
      end
      S_LOAD: node_we = 1'b1;
      S_U_RD: key_ra = leaf ? b : mid;
      S_U_CMP: begin
        if (leaf && key_qa == key) begin
          node_we = 1'b1;
          node_wd = '{idx: eidx, score: esc};
        end
      end
      S_P_WR: begin
        node_we = 1'b1;
        node_wd = (node_qa.score >= node_qb.score) ? node_qa : node_qb;
      end
      S_Q_EVAL: node_ra = n;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.opcode == OP_LOAD) begin
      key_mem[cmd.slot_index] <= cmd.key_value;
    end
    key_qa <= key_mem[key_ra];
    key_qb <= key_mem[key_rb];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_qa <= node_mem[node_ra];
    node_qb <= node_mem[node_rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      key_count <= CNT_W'(1);
      done      <= 1'b0;
      sp        <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        key_count <= cfg_wdata;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + NODE_W'(1);
          if (clr == NODE_W'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          n    <= NODE_W'(1);
          b    <= '0;
          e    <= last;
          sp   <= '0;
          acc  <= NODE_EMPTY;
          key  <= cmd.key_value;
          eidx <= cmd.entry_index;
          esc  <= cmd.score;
          lo   <= cmd.range_low;
          hi   <= cmd.range_high;
          load_slot <= cmd.slot_index;
          if (start) begin
            unique case (cmd.opcode)
              OP_LOAD:   if (cmd.slot_index <= last) state <= S_LOAD;
              OP_UPDATE: state <= S_U_RD;
              OP_QUERY:  state <= S_Q_RD;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          if (leaf) begin
            state <= S_IDLE;
          end else if (load_slot <= mid) begin
            n <= {n[NODE_W-2:0], 1'b0};
            e <= mid;
          end else begin
            n <= {n[NODE_W-2:0], 1'b1};
            b <= mid + SLOT_W'(1);
          end
        end
        S_U_RD: state <= S_U_CMP;
        S_U_CMP: begin
          if (leaf) begin
            if (n == NODE_W'(1)) begin
              state <= S_IDLE;
            end else begin
              n     <= n >> 1;
              state <= S_P_RD;
            end
          end else begin
            state <= S_U_RD;
            if (key <= key_qa) begin
              n <= {n[NODE_W-2:0], 1'b0};
              e <= mid;
            end else begin
              n <= {n[NODE_W-2:0], 1'b1};
              b <= mid + SLOT_W'(1);
            end
          end
        end
        S_P_RD: state <= S_P_WR;
        S_P_WR: begin
          if (n == NODE_W'(1)) begin
            state <= S_IDLE;
          end else begin
            n     <= n >> 1;
            state <= S_P_RD;
          end
        end
        S_Q_RD: state <= S_Q_EVAL;
        S_Q_EVAL, S_Q_FOLD: begin
          if (state == S_Q_EVAL && !miss && full) begin
            state <= S_Q_FOLD;
          end else if (state == S_Q_EVAL && !miss && !leaf) begin
            stack[sp] <= '{n: {n[NODE_W-2:0], 1'b1}, b: mid + SLOT_W'(1), e: e};
            sp <= sp + STACK_W'(1);
            n  <= {n[NODE_W-2:0], 1'b0};
            e  <= mid;
            state <= S_Q_RD;
          end else begin
            acc <= fold_out;
            if (sp == '0) begin
              result <= '{best_index: fold_out.idx, best_score: fold_out.score};
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              n  <= stack[sp - STACK_W'(1)].n;
              b  <= stack[sp - STACK_W'(1)].b;
              e  <= stack[sp - STACK_W'(1)].e;
              sp <= sp - STACK_W'(1);
              state <= S_Q_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/range_max_segment_tree_tb.sv =====
// Testbench: range maximum segment tree checked against a predictor on directed and random items.
`timescale 1ns / 1ps
module range_max_segment_tree_tb;
  import rmst_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  result_t result;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  range_max_segment_tree dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  int key_mem [MAX_KEYS];
  int node_idx [NODE_COUNT];
  int node_sc [NODE_COUNT];
  int slot_count;
  result_t best_q [$];
  int errors = 0;
  int queries_seen = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int loaded_keys [$];

  function automatic int last_slot();
    if (slot_count < 1) return 0;
    if (slot_count > MAX_KEYS) return MAX_KEYS - 1;
    return slot_count - 1;
  endfunction

  function automatic void put_node(int n, int ix, int sc);
    if (n < NODE_COUNT) begin
      node_idx[n] = ix;
      node_sc[n] = sc;
    end
  endfunction

  function automatic void get_node(int n, output int ix, output int sc);
    if (n < NODE_COUNT) begin
      ix = node_idx[n];
      sc = node_sc[n];
    end else begin
      ix = INDEX_NONE;
      sc = SCORE_MIN;
    end
  endfunction

  function automatic void clear_leaf_path(int slot, int n, int b, int e);
    int mid;
    put_node(n, INDEX_NONE, SCORE_MIN);
    if (b == e) return;
    mid = (b + e) / 2;
    if (slot <= mid) clear_leaf_path(slot, 2 * n, b, mid);
    else clear_leaf_path(slot, 2 * n + 1, mid + 1, e);
  endfunction

  function automatic void store_entry(int key, int ix, int sc, int n, int b, int e);
    int mid, li, ls, ri, rs;
    if (b == e) begin
      if (key_mem[b] == key) put_node(n, ix, sc);
      return;
    end
    mid = (b + e) / 2;
    if (key <= key_mem[mid]) store_entry(key, ix, sc, 2 * n, b, mid);
    else store_entry(key, ix, sc, 2 * n + 1, mid + 1, e);
    get_node(2 * n, li, ls);
    get_node(2 * n + 1, ri, rs);
    if (ls >= rs) put_node(n, li, ls);
    else put_node(n, ri, rs);
  endfunction

  function automatic void range_best(int lo, int hi, int n, int b, int e,
                                     output int ix, output int sc);
    int kb, ke, mid, li, ls, ri, rs;
    kb = key_mem[b];
    ke = key_mem[e];
    if (lo > ke || hi < kb) begin
      ix = INDEX_NONE;
      sc = SCORE_MIN;
      return;
    end
    if (kb >= lo && ke <= hi) begin
      get_node(n, ix, sc);
      return;
    end
    if (b == e) begin
      ix = INDEX_NONE;
      sc = SCORE_MIN;
      return;
    end
    mid = (b + e) / 2;
    range_best(lo, hi, 2 * n, b, mid, li, ls);
    range_best(lo, hi, 2 * n + 1, mid + 1, e, ri, rs);
    if (ls == SCORE_MIN || (rs != SCORE_MIN && rs > ls)) begin
      ix = ri;
      sc = rs;
    end else begin
      ix = li;
      sc = ls;
    end
  endfunction

  function automatic void apply_item(cmd_t c);
    int ix, sc;
    result_t r;
    case (c.opcode)
      OP_LOAD: begin
        key_mem[c.slot_index] = c.key_value;
        if (int'(c.slot_index) <= last_slot())
          clear_leaf_path(c.slot_index, 1, 0, last_slot());
      end
      OP_UPDATE: store_entry(c.key_value, c.entry_index, c.score, 1, 0, last_slot());
      OP_QUERY: begin
        range_best(c.range_low, c.range_high, 1, 0, last_slot(), ix, sc);
        r.best_index = ix;
        r.best_score = sc;
        best_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (best_q.size() == 0) begin
        $error("result with no query outstanding: index %0d score %0d",
               result.best_index, result.best_score);
        errors++;
      end else begin
        result_t want;
        want = best_q.pop_front();
        queries_seen++;
        if (result.best_index !== want.best_index) begin
          $error("best_index expected %0d actual %0d", want.best_index, result.best_index);
          errors++;
        end
        if (result.best_score !== want.best_score) begin
          $error("best_score expected %0d actual %0d", want.best_score, result.best_score);
          errors++;
        end
      end
    end
  end

  task automatic send_item(cmd_t c);
    bit sent;
    sent = 1'b0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          start <= 1'b0;
        end
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    while (!sent) begin
      @(negedge clk);
      if (!busy) begin
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        apply_item(c);
        items_sent++;
        sent = 1'b1;
      end else begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (best_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_slot_count(int v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_W'(v);
    @(posedge clk);
    slot_count = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cmd_t make_cmd(logic [1:0] op, int slot, int key, int ix, int sc,
                                    int lo, int hi);
    cmd_t c;
    c.opcode = op;
    c.slot_index = SLOT_W'(slot);
    c.key_value = key;
    c.entry_index = ix;
    c.score = sc;
    c.range_low = lo;
    c.range_high = hi;
    return c;
  endfunction

  function automatic int rand_word();
    return int'($urandom);
  endfunction

  task automatic load_sorted(int n);
    int ks [$];
    ks = {};
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 5) == 0) ks.push_back(ks[i - 1]);
      else if ($urandom_range(0, 1) == 0) ks.push_back($urandom_range(0, 4000) - 2000);
      else ks.push_back(rand_word());
    end
    ks.sort();
    loaded_keys = ks;
    for (int i = 0; i < n; i++)
      send_item(make_cmd(OP_LOAD, i, ks[i], rand_word(), rand_word(), rand_word(), rand_word()));
  endtask

  function automatic int pick_key();
    int k;
    k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
    if ($urandom_range(0, 4) == 0) k = k + $urandom_range(0, 2) - 1;
    if ($urandom_range(0, 9) == 0) k = rand_word();
    return k;
  endfunction

  task automatic random_ops(int n, int count);
    int a, b, sc, r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      sc = ($urandom_range(0, 9) == 0) ? int'(SCORE_MIN) : rand_word();
      if (r < 45) begin
        send_item(make_cmd(OP_UPDATE, $urandom_range(0, 1023), pick_key(),
                           ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 32'h7fffffff),
                           sc, rand_word(), rand_word()));
      end else if (r < 88) begin
        a = pick_key();
        b = pick_key();
        if ($urandom_range(0, 4) != 0 && a > b) begin
          int t;
          t = a;
          a = b;
          b = t;
        end
        send_item(make_cmd(OP_QUERY, $urandom_range(0, 1023), rand_word(), rand_word(),
                           rand_word(), a, b));
      end else if (r < 93) begin
        a = $urandom_range(0, 1023);
        if (a < count && $urandom_range(0, 3) != 0) b = loaded_keys[a];
        else b = rand_word();
        send_item(make_cmd(OP_LOAD, a, b, rand_word(), rand_word(), rand_word(), rand_word()));
        if (a < count) loaded_keys[a] = b;
      end else begin
        send_item(make_cmd(2'd3, $urandom_range(0, 1023), rand_word(), rand_word(),
                           rand_word(), rand_word(), rand_word()));
      end
    end
  endtask

  task automatic test_directed();
    int mn, mx;
    mn = SCORE_MIN;
    mx = 32'h7fffffff;
    gaps_on = 1'b0;
    set_slot_count(4);
    send_item(make_cmd(OP_LOAD, 0, mn, 0, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 1, -5, 0, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 2, 7, 0, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 3, mx, 0, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 1023, -1, -1, -1, -1, -1));
    send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, mn, mx));
    send_item(make_cmd(OP_UPDATE, 0, mn, mx, mx, 0, 0));
    send_item(make_cmd(OP_UPDATE, 0, mx, -1, mn, 0, 0));
    send_item(make_cmd(OP_UPDATE, 0, -5, 3, mx, 0, 0));
    send_item(make_cmd(OP_UPDATE, 0, 7, 9, 100, 0, 0));
    send_item(make_cmd(OP_UPDATE, 0, 6, 11, 5000, 0, 0));
    send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, mn, mx));
    send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, 0, mx));
    send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, mx, mx));
    send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, 8, 100));
    send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, 7, -5));
    send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, mn, mn));
    send_item(make_cmd(2'd3, 1023, mx, mx, mx, mx, mx));
    send_item(make_cmd(OP_LOAD, 1, -5, 0, 0, 0, 0));
    send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, mn, mx));
    gaps_on = 1'b1;
  endtask

  task automatic test_key_counts();
    int counts [8] = '{0, 1, 2, 3, 17, 100, 1024, 2047};
    int used;
    for (int p = 0; p < 8; p++) begin
      set_slot_count(counts[p]);
      used = last_slot() + 1;
      if (counts[p] != 2047) load_sorted(used);
      gaps_on = (p % 3 != 1);
      random_ops(32, used);
      if (p == 4) drain();
      random_ops(32, used);
    end
  endtask

  task automatic test_unsorted_keys();
    set_slot_count(9);
    for (int i = 0; i < 9; i++)
      send_item(make_cmd(OP_LOAD, i, rand_word(), 0, 0, 0, 0));
    for (int i = 0; i < 9; i++) loaded_keys[i] = key_mem[i];
    random_ops(60, 9);
  endtask

  initial begin
    for (int i = 0; i < MAX_KEYS; i++) key_mem[i] = 0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      node_idx[i] = INDEX_NONE;
      node_sc[i] = SCORE_MIN;
    end
    slot_count = 1;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_key_counts();
    test_unsorted_keys();
    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d items, checked %0d query results", items_sent, queries_seen);
    $display("Covered key counts 0 to 2047, sorted and unsorted keys, opcode 3");
    if (errors == 0 && best_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (best_q.size() != 0) $error("%0d query results never arrived", best_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rmst_pkg.sv
hdl/range_max_segment_tree.sv
sim/range_max_segment_tree_tb.sv
